FILE: sv/temh_pkg.sv
// ----------------------------------------------------------------------------
// temh_pkg
// Shared types and codes for the timer expiry queue.
// ----------------------------------------------------------------------------
`default_nettype none

package temh_pkg;

   localparam int ID_BITS        = 5;
   localparam int ID_COUNT       = 32;
   localparam int CAPACITY_DEF   = 32;
   localparam int TIME_BITS_DEF  = 48;

   localparam logic [1:0] CMD_ADD      = 2'd0;
   localparam logic [1:0] CMD_REMOVE   = 2'd1;
   localparam logic [1:0] CMD_DETECT   = 2'd2;
   localparam logic [1:0] CMD_RESERVED = 2'd3;

   localparam logic [1:0] STS_OK         = 2'd0;
   localparam logic [1:0] STS_FULL       = 2'd1;
   localparam logic [1:0] STS_DUPLICATE  = 2'd2;
   localparam logic [1:0] STS_NOT_QUEUED = 2'd3;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_REMOVE,
      CELL_POP
   } cell_op_type;

   typedef struct packed {
      cell_op_type         op;
      logic [ID_BITS-1:0]  id;
   } cell_ctl_type;

   typedef struct packed {
      logic                valid;
      logic [ID_BITS-1:0]  id;
   } cell_link_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

endpackage

`default_nettype wire

FILE: sv/temh_cell.sv
// ----------------------------------------------------------------------------
// temh_cell
// One slot of the sorted timer chain: holds a (time, id) entry and trades
// it with its neighbours on insert, remove and pop.
// ----------------------------------------------------------------------------
`default_nettype none

module temh_cell #(
   parameter int TIME_BITS = temh_pkg::TIME_BITS_DEF
) (
   input  wire                          clock,
   input  wire                          reset,
   input  temh_pkg::cell_ctl_type       ctl,
   input  wire [TIME_BITS-1:0]          new_time,
   input  temh_pkg::cell_link_type      prev_link,
   input  wire [TIME_BITS-1:0]          prev_time,
   input  wire                          prev_lt,
   input  wire                          seen_in,
   input  temh_pkg::cell_link_type      next_link,
   input  wire [TIME_BITS-1:0]          next_time,
   output temh_pkg::cell_link_type      link,
   output logic [TIME_BITS-1:0]         key_time,
   output logic                         lt,
   output logic                         seen_out
);

   logic                               valid_ff, valid_in;
   logic [temh_pkg::ID_BITS-1:0]       id_ff, id_in;
   logic [TIME_BITS-1:0]               time_ff, time_in;
   logic                               hit;

   assign hit      = valid_ff && (id_ff == ctl.id);
   assign seen_out = seen_in || hit;
   assign lt       = !valid_ff || ({new_time, ctl.id} < {time_ff, id_ff});
   assign link     = '{valid: valid_ff, id: id_ff};
   assign key_time = time_ff;

   always_comb begin
      valid_in = valid_ff;
      id_in    = id_ff;
      time_in  = time_ff;
      case (ctl.op)
         temh_pkg::CELL_INSERT: begin
            if (prev_lt) begin
               valid_in = prev_link.valid;
               id_in    = prev_link.id;
               time_in  = prev_time;
            end else if (lt) begin
               valid_in = 1'b1;
               id_in    = ctl.id;
               time_in  = new_time;
            end
         end
         temh_pkg::CELL_REMOVE: begin
            if (seen_out) begin
               valid_in = next_link.valid;
               id_in    = next_link.id;
               time_in  = next_time;
            end
         end
         temh_pkg::CELL_POP: begin
            valid_in = next_link.valid;
            id_in    = next_link.id;
            time_in  = next_time;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      id_ff   <= id_in;
      time_ff <= time_in;
   end

endmodule

`default_nettype wire

FILE: sv/temh_ctrl.sv
// ----------------------------------------------------------------------------
// temh_ctrl
// Command sequencer: captures a request beat, drives the cell chain and
// holds the result beat until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module temh_ctrl #(
   parameter int CELLS     = temh_pkg::CAPACITY_DEF,
   parameter int TIME_BITS = temh_pkg::TIME_BITS_DEF
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_stall,
   input  wire [1:0]                        req_command,
   input  wire [temh_pkg::ID_BITS-1:0]      req_timer_id,
   input  wire [TIME_BITS-1:0]              req_expiry_time,
   input  wire [TIME_BITS-1:0]              req_current_time,
   output logic                             rsp_valid,
   input  wire                              rsp_stall,
   output logic [temh_pkg::ID_BITS-1:0]     rsp_expired_id,
   output logic                             rsp_fired,
   output logic [1:0]                       rsp_status,
   output logic                             rsp_last,
   output temh_pkg::cell_ctl_type           ctl,
   output logic [TIME_BITS-1:0]             new_time,
   input  temh_pkg::cell_link_type          head_link,
   input  wire [TIME_BITS-1:0]              head_time,
   input  temh_pkg::cell_link_type          second_link,
   input  wire [TIME_BITS-1:0]              second_time,
   input  wire                              hit_any
);

   localparam int CW = $clog2(CELLS + 1);

   temh_pkg::state_type                state_ff, state_in;
   logic [CW-1:0]                      count_ff, count_in;
   logic [1:0]                         cmd_ff;
   logic [temh_pkg::ID_BITS-1:0]       id_ff;
   logic [TIME_BITS-1:0]               expiry_ff, now_ff;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [temh_pkg::ID_BITS-1:0]       rsp_id_ff, rsp_id_in;
   logic                               rsp_fired_ff, rsp_fired_in;
   logic [1:0]                         rsp_status_ff, rsp_status_in;
   logic                               rsp_last_ff, rsp_last_in;
   logic                               accept, out_free, head_due, second_due;
   temh_pkg::cell_op_type              op;

   assign req_stall  = (state_ff != temh_pkg::ST_IDLE);
   assign accept     = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign head_due   = head_link.valid && (head_time <= now_ff);
   assign second_due = second_link.valid && (second_time <= now_ff);

   assign ctl      = '{op: op, id: id_ff};
   assign new_time = expiry_ff;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_expired_id = rsp_id_ff;
   assign rsp_fired      = rsp_fired_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_last       = rsp_last_ff;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      op            = temh_pkg::CELL_HOLD;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_id_in     = rsp_id_ff;
      rsp_fired_in  = rsp_fired_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      case (state_ff)
         temh_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = temh_pkg::ST_EXEC;
            end
         end
         temh_pkg::ST_EXEC: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_id_in     = '0;
               rsp_fired_in  = 1'b0;
               rsp_status_in = temh_pkg::STS_OK;
               rsp_last_in   = 1'b1;
               state_in      = temh_pkg::ST_IDLE;
               case (cmd_ff)
                  temh_pkg::CMD_ADD: begin
                     if (hit_any) begin
                        rsp_status_in = temh_pkg::STS_DUPLICATE;
                     end else if (count_ff == CW'(CELLS)) begin
                        rsp_status_in = temh_pkg::STS_FULL;
                     end else begin
                        op       = temh_pkg::CELL_INSERT;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  temh_pkg::CMD_REMOVE: begin
                     if (!hit_any) begin
                        rsp_status_in = temh_pkg::STS_NOT_QUEUED;
                     end else begin
                        op       = temh_pkg::CELL_REMOVE;
                        count_in = count_ff - 1'b1;
                     end
                  end
                  temh_pkg::CMD_DETECT: begin
                     if (head_due) begin
                        op           = temh_pkg::CELL_POP;
                        count_in     = count_ff - 1'b1;
                        rsp_id_in    = head_link.id;
                        rsp_fired_in = 1'b1;
                        rsp_last_in  = !second_due;
                        if (second_due) begin
                           state_in = temh_pkg::ST_EXEC;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         default: begin
            state_in = temh_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= temh_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         cmd_ff    <= req_command;
         id_ff     <= req_timer_id;
         expiry_ff <= req_expiry_time;
         now_ff    <= req_current_time;
      end
      rsp_id_ff     <= rsp_id_in;
      rsp_fired_ff  <= rsp_fired_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

endmodule

`default_nettype wire

FILE: sv/timer_expiry_min_heap.sv
// Timer expiry queue, kept as a sorted chain of cells (earliest at the head).
// A request beat is captured into the sequencer's registers; its first result
// beat is then registered from the execute state once the output is free. Add
// and remove give a single result beat. Detect gives one result beat per cycle
// while the output is not stalled. The sequencer takes one request at a time and
// stalls new ones until it is idle again. Synchronous reset empties the chain.
`default_nettype none

module timer_expiry_min_heap #(
   parameter int CAPACITY  = temh_pkg::CAPACITY_DEF,
   parameter int TIME_BITS = temh_pkg::TIME_BITS_DEF
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_stall,
   input  wire [1:0]                        req_command,
   input  wire [temh_pkg::ID_BITS-1:0]      req_timer_id,
   input  wire [TIME_BITS-1:0]              req_expiry_time,
   input  wire [TIME_BITS-1:0]              req_current_time,
   output logic                             rsp_valid,
   input  wire                              rsp_stall,
   output logic [temh_pkg::ID_BITS-1:0]     rsp_expired_id,
   output logic                             rsp_fired,
   output logic [1:0]                       rsp_status,
   output logic                             rsp_last
);

   localparam int CELLS = (CAPACITY < temh_pkg::ID_COUNT) ? CAPACITY : temh_pkg::ID_COUNT;

   temh_pkg::cell_ctl_type     ctl;
   logic [TIME_BITS-1:0]       new_time;
   temh_pkg::cell_link_type    links [CELLS];
   logic [TIME_BITS-1:0]       times [CELLS];
   logic                       lts   [CELLS];
   logic                       seens [CELLS];

   temh_ctrl #(
      .CELLS     (CELLS),
      .TIME_BITS (TIME_BITS)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_timer_id     (req_timer_id),
      .req_expiry_time  (req_expiry_time),
      .req_current_time (req_current_time),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_expired_id   (rsp_expired_id),
      .rsp_fired        (rsp_fired),
      .rsp_status       (rsp_status),
      .rsp_last         (rsp_last),
      .ctl              (ctl),
      .new_time         (new_time),
      .head_link        (links[0]),
      .head_time        (times[0]),
      .second_link      (links[1]),
      .second_time      (times[1]),
      .hit_any          (seens[CELLS-1])
   );

   for (genvar i = 0; i < CELLS; i++) begin : g_cell
      temh_pkg::cell_link_type  prev_link, next_link;
      logic [TIME_BITS-1:0]     prev_time, next_time;
      logic                     prev_lt, seen_in;

      if (i == 0) begin : g_first
         assign prev_link = '{valid: 1'b0, id: '0};
         assign prev_time = '0;
         assign prev_lt   = 1'b0;
         assign seen_in   = 1'b0;
      end else begin : g_mid
         assign prev_link = links[i-1];
         assign prev_time = times[i-1];
         assign prev_lt   = lts[i-1];
         assign seen_in   = seens[i-1];
      end

      if (i == CELLS - 1) begin : g_last
         assign next_link = '{valid: 1'b0, id: '0};
         assign next_time = '0;
      end else begin : g_inner
         assign next_link = links[i+1];
         assign next_time = times[i+1];
      end

      temh_cell #(
         .TIME_BITS (TIME_BITS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .new_time  (new_time),
         .prev_link (prev_link),
         .prev_time (prev_time),
         .prev_lt   (prev_lt),
         .seen_in   (seen_in),
         .next_link (next_link),
         .next_time (next_time),
         .link      (links[i]),
         .key_time  (times[i]),
         .lt        (lts[i]),
         .seen_out  (seens[i])
      );
   end

endmodule

`default_nettype wire

FILE: sv/temh_checker.sv
// ----------------------------------------------------------------------------
// temh_checker
// Port-level checks on the timer expiry queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module temh_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_valid,
   input wire        req_stall,
   input wire        rsp_valid,
   input wire        rsp_stall,
   input wire [4:0]  rsp_expired_id,
   input wire        rsp_fired,
   input wire [1:0]  rsp_status,
   input wire        rsp_last
);

   a_fired_ok : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fired |-> rsp_status == temh_pkg::STS_OK)
      else $error("fired beat with non-ok status");

   a_idle_beat : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_fired |-> rsp_last && rsp_expired_id == 5'd0)
      else $error("non-firing beat not last or with id");

   a_one_at_a_time : assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while previous one in flight");

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_expired_id)
         && $stable(rsp_status) && $stable(rsp_last) && $stable(rsp_fired))
      else $error("stalled result beat changed");

endmodule

bind timer_expiry_min_heap temh_checker u_temh_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_expired_id (rsp_expired_id),
   .rsp_fired      (rsp_fired),
   .rsp_status     (rsp_status),
   .rsp_last       (rsp_last)
);

`default_nettype wire
